FILE: hw/rtl/dhd_pkg.sv
// dhd_pkg: shared types, constants and result codes for the datagram header deframer.
// Used by dhd_core, dhd_fifo, datagram_header_deframer and dhd_checker. No dependencies.
`timescale 1ns / 1ps

package dhd_pkg;

    // Header geometry
    localparam int unsigned HDR_LEN = 12;
    localparam int unsigned POS_W   = 17;
    localparam int unsigned FIFO_DEPTH = 3;

    // Header byte positions
    localparam logic [3:0] POS_FLAGS_HI = 4'd0;
    localparam logic [3:0] POS_FLAGS_LO = 4'd1;
    localparam logic [3:0] POS_ID_HI    = 4'd2;
    localparam logic [3:0] POS_ID_LO    = 4'd3;
    localparam logic [3:0] POS_NLEN     = 4'd5;
    localparam logic [3:0] POS_DLEN_HI  = 4'd6;
    localparam logic [3:0] POS_DLEN_LO  = 4'd7;
    localparam logic [3:0] POS_ENV_HI   = 4'd8;
    localparam logic [3:0] POS_ENV_LO   = 4'd9;
    localparam logic [3:0] POS_HDR_LAST = 4'd11;

    // Result kinds
    localparam logic [2:0] KIND_HEADER    = 3'd0;
    localparam logic [2:0] KIND_NAME      = 3'd1;
    localparam logic [2:0] KIND_PAYLOAD   = 3'd2;
    localparam logic [2:0] KIND_DONE      = 3'd3;
    localparam logic [2:0] KIND_TOO_SHORT = 3'd4;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] flag_bits;
        logic [15:0] message_id;
        logic [7:0]  name_length;
        logic [15:0] payload_length;
        logic [15:0] environment;
        logic [7:0]  section_byte;
        logic [16:0] frame_length;
        logic        last;
    } res_t;

    // Up to two results produced by one input byte, in order
    typedef struct packed {
        logic [1:0] count;
        res_t       first;
        res_t       second;
    } push_t;

    // Next slot of the three-entry result queue
    function automatic logic [1:0] ptr_inc(input logic [1:0] p);
        ptr_inc = (p == 2'(FIFO_DEPTH - 1)) ? 2'd0 : p + 2'd1;
    endfunction

endpackage

FILE: hw/rtl/datagram_header_deframer.sv
// datagram_header_deframer: top level, byte-stream datagram header deframer.
// Depends on dhd_pkg, dhd_core and dhd_fifo.
//
//  channel | ports                         | direction | beat
//  s_      | byte_value, end_of_buffer     | in        | one buffer byte
//  m_      | kind, header fields, section_ | out       | one result (header, name/
//          | byte, frame_length, last      |           | payload byte, done, too_short)
//
// One byte per cycle while results are drained each cycle and no byte yields two;
// a byte that yields two results holds off the next byte, set by the single read port of the
// three-entry result queue. s_ready depends only on the queue fill level.
// Results are registered in the result queue before they reach m_, behind any earlier results.
// Reset (aresetn low, synchronous) empties the queue and rearms the deframer.
`timescale 1ns / 1ps

module datagram_header_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_value,
    input  logic        s_end_of_buffer,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [15:0] m_flag_bits,
    output logic [15:0] m_message_id,
    output logic [7:0]  m_name_length,
    output logic [15:0] m_payload_length,
    output logic [15:0] m_environment,
    output logic [7:0]  m_section_byte,
    output logic [16:0] m_frame_length,
    output logic        m_last
);

    dhd_pkg::push_t push;
    dhd_pkg::res_t  res;
    logic           in_fire;
    logic [1:0]     level;

    assign in_fire = s_valid && s_ready;

    dhd_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_fire       (in_fire),
        .byte_value    (s_byte_value),
        .end_of_buffer (s_end_of_buffer),
        .push          (push)
    );

    dhd_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room    (s_ready),
        .level   (level),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (res)
    );

    assign m_kind           = res.kind;
    assign m_flag_bits      = res.flag_bits;
    assign m_message_id     = res.message_id;
    assign m_name_length    = res.name_length;
    assign m_payload_length = res.payload_length;
    assign m_environment    = res.environment;
    assign m_section_byte   = res.section_byte;
    assign m_frame_length   = res.frame_length;
    assign m_last           = res.last;

    // Checks
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        level != 2'd0 || !m_valid)
        else $error("result valid with empty queue");

    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == dhd_pkg::KIND_DONE || m_kind == dhd_pkg::KIND_TOO_SHORT)
            |-> m_last)
        else $error("done or too_short not marked last");

    a_done_length: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == dhd_pkg::KIND_DONE
            |-> m_frame_length >= 17'(dhd_pkg::HDR_LEN))
        else $error("done with frame length below header size");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |-> level <= 2'd1)
        else $error("byte taken without room for two results");

endmodule

FILE: hw/rtl/dhd_core.sv
// dhd_core: deframing state and per-byte result logic.
// Depends on dhd_pkg.
`timescale 1ns / 1ps

module dhd_core (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_fire,
    input  logic [7:0]    byte_value,
    input  logic          end_of_buffer,
    output dhd_pkg::push_t push
);

    localparam logic [16:0] HdrLen = 17'(dhd_pkg::HDR_LEN);

    logic [16:0] pos_reg,   pos_next;
    logic [15:0] flags_reg, flags_next;
    logic [15:0] id_reg,    id_next;
    logic [7:0]  nlen_reg,  nlen_next;
    logic [15:0] dlen_reg,  dlen_next;
    logic [15:0] env_reg,   env_next;
    logic        zero_seen_reg, zero_seen_next;
    logic        finished_reg,  finished_next;

    logic [17:0] pos_inc;
    logic        in_header;
    logic [16:0] name_end;
    logic [16:0] total;
    logic        zs_eff;
    logic        primary;
    logic        done;
    dhd_pkg::res_t prim_res, sec_res, blank;

    assign pos_inc   = {1'b0, pos_reg} + 18'd1;
    assign in_header = (pos_reg < HdrLen);
    assign name_end  = HdrLen + {9'd0, nlen_reg};

    // Header field capture, big-endian
    always_comb begin
        flags_next = flags_reg;
        id_next    = id_reg;
        nlen_next  = nlen_reg;
        dlen_next  = dlen_reg;
        env_next   = env_reg;
        if (in_header) begin
            case (pos_reg[3:0])
                dhd_pkg::POS_FLAGS_HI, dhd_pkg::POS_FLAGS_LO:
                    flags_next = {flags_reg[7:0], byte_value};
                dhd_pkg::POS_ID_HI, dhd_pkg::POS_ID_LO:
                    id_next = {id_reg[7:0], byte_value};
                dhd_pkg::POS_NLEN:
                    nlen_next = byte_value;
                dhd_pkg::POS_DLEN_HI, dhd_pkg::POS_DLEN_LO:
                    dlen_next = {dlen_reg[7:0], byte_value};
                dhd_pkg::POS_ENV_HI, dhd_pkg::POS_ENV_LO:
                    env_next = {env_reg[7:0], byte_value};
                default: ;
            endcase
        end
    end

    // Frame length and completion test
    assign total = HdrLen + {9'd0, nlen_next} + {1'b0, dlen_next};
    assign done  = (pos_inc >= {1'b0, HdrLen}) && (pos_inc == {1'b0, total});

    // Zero fill within a section, strncpy style
    assign zs_eff = (pos_reg == HdrLen || pos_reg == name_end) ? 1'b0 : zero_seen_reg;

    // Result formation
    always_comb begin
        blank    = '0;
        prim_res = '0;
        sec_res  = '0;
        primary  = 1'b0;
        if (in_header) begin
            primary                 = (pos_reg[3:0] == dhd_pkg::POS_HDR_LAST);
            prim_res.kind           = dhd_pkg::KIND_HEADER;
            prim_res.flag_bits      = flags_next;
            prim_res.message_id     = id_next;
            prim_res.name_length    = nlen_next;
            prim_res.payload_length = dlen_next;
            prim_res.environment    = env_next;
        end else begin
            primary               = 1'b1;
            prim_res.kind         = (pos_reg < name_end) ? dhd_pkg::KIND_NAME
                                                         : dhd_pkg::KIND_PAYLOAD;
            prim_res.section_byte = zs_eff ? 8'd0 : byte_value;
        end
        if (done) begin
            sec_res.kind         = dhd_pkg::KIND_DONE;
            sec_res.frame_length = total;
        end else begin
            sec_res.kind = dhd_pkg::KIND_TOO_SHORT;
        end
        sec_res.last = 1'b1;

        push = '{count: 2'd0, first: blank, second: blank};
        if (in_fire && !finished_reg) begin
            if (primary && (done || end_of_buffer)) begin
                push.count  = 2'd2;
                push.first  = prim_res;
                push.second = sec_res;
            end else if (primary) begin
                push.count      = 2'd1;
                push.first      = prim_res;
                push.first.last = 1'b1;
            end else if (done || end_of_buffer) begin
                push.count = 2'd1;
                push.first = sec_res;
            end
        end
    end

    // Position, zero tracking and frame completion
    always_comb begin
        pos_next       = pos_reg;
        zero_seen_next = zero_seen_reg;
        finished_next  = finished_reg;
        if (in_fire) begin
            if (finished_reg) begin
                if (end_of_buffer) begin
                    finished_next = 1'b0;
                    pos_next      = '0;
                    zero_seen_next = 1'b0;
                end
            end else begin
                if (!in_header)
                    zero_seen_next = zs_eff | (byte_value == 8'd0);
                if (done)
                    finished_next = 1'b1;
                if (end_of_buffer) begin
                    pos_next       = '0;
                    zero_seen_next = 1'b0;
                    finished_next  = 1'b0;
                end else begin
                    pos_next = pos_inc[16:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            flags_reg     <= '0;
            id_reg        <= '0;
            nlen_reg      <= '0;
            dlen_reg      <= '0;
            env_reg       <= '0;
            zero_seen_reg <= 1'b0;
            finished_reg  <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            zero_seen_reg <= zero_seen_next;
            finished_reg  <= finished_next;
            if (in_fire && !finished_reg) begin
                flags_reg <= flags_next;
                id_reg    <= id_next;
                nlen_reg  <= nlen_next;
                dlen_reg  <= dlen_next;
                env_reg   <= env_next;
            end
        end
    end

endmodule

FILE: hw/rtl/dhd_fifo.sv
// dhd_fifo: three-entry result queue, up to two writes and one read per cycle.
// Depends on dhd_pkg.
`timescale 1ns / 1ps

module dhd_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  dhd_pkg::push_t push,
    output logic           room,
    output logic [1:0]     level,
    output logic           m_valid,
    input  logic           m_ready,
    output dhd_pkg::res_t  m_res
);

    dhd_pkg::res_t mem [dhd_pkg::FIFO_DEPTH];

    logic [1:0] wr_reg, wr_next;
    logic [1:0] rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       pop;
    logic [1:0] wr_second;

    assign pop       = m_valid && m_ready;
    assign wr_second = dhd_pkg::ptr_inc(wr_reg);

    // Room for a worst-case beat of two results, registered-only decision
    assign room    = (cnt_reg <= 2'd1);
    assign level   = cnt_reg;
    assign m_valid = (cnt_reg != 2'd0);
    assign m_res   = mem[rd_reg];

    // Pointer and fill bookkeeping
    always_comb begin
        wr_next  = wr_reg;
        rd_next  = pop ? dhd_pkg::ptr_inc(rd_reg) : rd_reg;
        cnt_next = cnt_reg + push.count - {1'b0, pop};
        case (push.count)
            2'd1:    wr_next = wr_second;
            2'd2:    wr_next = dhd_pkg::ptr_inc(wr_second);
            default: wr_next = wr_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Result storage
    always_ff @(posedge aclk) begin
        if (push.count != 2'd0)
            mem[wr_reg] <= push.first;
        if (push.count == 2'd2)
            mem[wr_second] <= push.second;
    end

endmodule

FILE: tb/dhd_checker.sv
// dhd_checker: watches both channels of datagram_header_deframer, predicts each result beat
// and compares it field by field. Depends on dhd_pkg for res_t and the result kinds.
`timescale 1ns / 1ps

module dhd_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_byte_value,
    input  logic        s_end_of_buffer,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_kind,
    input  logic [15:0] m_flag_bits,
    input  logic [15:0] m_message_id,
    input  logic [7:0]  m_name_length,
    input  logic [15:0] m_payload_length,
    input  logic [15:0] m_environment,
    input  logic [7:0]  m_section_byte,
    input  logic [16:0] m_frame_length,
    input  logic        m_last,
    output int          fail_count,
    output int          outstanding,
    output int          results_checked,
    output int          frames_done,
    output int          buffers_short
);

    // Deframer state as seen from outside
    logic [dhd_pkg::POS_W-1:0] byte_pos;
    logic [15:0]      flags_acc;
    logic [15:0]      id_acc;
    logic [7:0]       nlen_acc;
    logic [15:0]      dlen_acc;
    logic [15:0]      env_acc;
    logic             zero_run;
    logic             frame_closed;

    // Results still owed by the block, oldest first
    dhd_pkg::res_t expected_results[$];
    dhd_pkg::res_t want;
    int   errors    = 0;
    int   checked   = 0;
    int   n_done    = 0;
    int   n_short   = 0;

    function automatic dhd_pkg::res_t blank_result(input logic [2:0] kind);
        dhd_pkg::res_t r;
        r = '0;
        r.kind = kind;
        return r;
    endfunction

    task automatic rearm_frame();
        byte_pos     = '0;
        zero_run     = 1'b0;
        frame_closed = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [16:0] exp_v,
                               input logic [16:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
            errors++;
        end
    endtask

    // Work out the result beats caused by one accepted input byte
    task automatic predict_beat(input logic [7:0] b, input logic eob);
        dhd_pkg::res_t out_q[$];
        dhd_pkg::res_t r;
        int unsigned p;
        int unsigned name_end;
        int unsigned total;
        logic [7:0]  v;
        p = byte_pos;
        if (frame_closed) begin
            // trailing bytes after a complete frame are dropped
            if (eob) rearm_frame();
        end else begin
            if (p < dhd_pkg::HDR_LEN) begin
                case (byte_pos)
                    dhd_pkg::POS_FLAGS_HI, dhd_pkg::POS_FLAGS_LO:
                        flags_acc = {flags_acc[7:0], b};
                    dhd_pkg::POS_ID_HI, dhd_pkg::POS_ID_LO:
                        id_acc = {id_acc[7:0], b};
                    dhd_pkg::POS_NLEN:
                        nlen_acc = b;
                    dhd_pkg::POS_DLEN_HI, dhd_pkg::POS_DLEN_LO:
                        dlen_acc = {dlen_acc[7:0], b};
                    dhd_pkg::POS_ENV_HI, dhd_pkg::POS_ENV_LO:
                        env_acc = {env_acc[7:0], b};
                    default: ;
                endcase
                if (byte_pos == dhd_pkg::POS_HDR_LAST) begin
                    r                = blank_result(dhd_pkg::KIND_HEADER);
                    r.flag_bits      = flags_acc;
                    r.message_id     = id_acc;
                    r.name_length    = nlen_acc;
                    r.payload_length = dlen_acc;
                    r.environment    = env_acc;
                    out_q.push_back(r);
                end
            end else begin
                // section byte, zero-filled after the first zero of its section
                name_end = dhd_pkg::HDR_LEN + nlen_acc;
                r = blank_result((p < name_end) ? dhd_pkg::KIND_NAME : dhd_pkg::KIND_PAYLOAD);
                if (p == dhd_pkg::HDR_LEN || p == name_end) zero_run = 1'b0;
                v = zero_run ? 8'h00 : b;
                if (b == 8'h00) zero_run = 1'b1;
                r.section_byte = v;
                out_q.push_back(r);
            end

            total = dhd_pkg::HDR_LEN + nlen_acc + dlen_acc;
            if (p + 1 >= dhd_pkg::HDR_LEN && p + 1 == total) begin
                r              = blank_result(dhd_pkg::KIND_DONE);
                r.frame_length = total[16:0];
                out_q.push_back(r);
                frame_closed = 1'b1;
                n_done++;
            end else if (eob) begin
                out_q.push_back(blank_result(dhd_pkg::KIND_TOO_SHORT));
                n_short++;
            end

            if (eob) rearm_frame();
            else byte_pos = byte_pos + 1'b1;

            foreach (out_q[i]) begin
                r      = out_q[i];
                r.last = (i == out_q.size() - 1);
                expected_results.push_back(r);
            end
        end
    endtask

    // Compare the result beat first: it always belongs to an earlier byte
    always @(posedge aclk) begin
        if (!aresetn) begin
            rearm_frame();
            flags_acc = '0;
            id_acc    = '0;
            nlen_acc  = '0;
            dlen_acc  = '0;
            env_acc   = '0;
            expected_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result beat of kind %0d with nothing expected", m_kind);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("kind", want.kind, m_kind);
                    check_field("flag_bits", want.flag_bits, m_flag_bits);
                    check_field("message_id", want.message_id, m_message_id);
                    check_field("name_length", want.name_length, m_name_length);
                    check_field("payload_length", want.payload_length, m_payload_length);
                    check_field("environment", want.environment, m_environment);
                    check_field("section_byte", want.section_byte, m_section_byte);
                    check_field("frame_length", want.frame_length, m_frame_length);
                    check_field("last", want.last, m_last);
                    checked++;
                end
            end
            if (s_valid && s_ready) predict_beat(s_byte_value, s_end_of_buffer);
        end
        fail_count      <= errors;
        outstanding     <= expected_results.size();
        results_checked <= checked;
        frames_done     <= n_done;
        buffers_short   <= n_short;
    end

endmodule

FILE: tb/tb_top.sv
// tb_top: stimulus and verdict for datagram_header_deframer; dhd_checker does the prediction.
// Depends on dhd_pkg, the deframer RTL and tb/dhd_checker.sv.
`timescale 1ns / 1ps

module tb_top;

    localparam int ITEM_TARGET = 1300;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AT     = 300;

    logic        aclk            = 1'b0;
    logic        aresetn         = 1'b0;
    logic        s_valid         = 1'b0;
    logic        s_ready;
    logic [7:0]  s_byte_value    = 8'h00;
    logic        s_end_of_buffer = 1'b0;
    logic        m_valid;
    logic        m_ready         = 1'b0;
    logic [2:0]  m_kind;
    logic [15:0] m_flag_bits;
    logic [15:0] m_message_id;
    logic [7:0]  m_name_length;
    logic [15:0] m_payload_length;
    logic [15:0] m_environment;
    logic [7:0]  m_section_byte;
    logic [16:0] m_frame_length;
    logic        m_last;

    int fail_count;
    int outstanding;
    int results_checked;
    int frames_done;
    int buffers_short;

    // Bytes of the buffer being built, and run statistics
    logic [7:0] buf_q[$];
    int         items_sent   = 0;
    int         bytes_sent   = 0;
    int         buffers_sent = 0;
    int         idle_cycles  = 0;
    logic       big_done     = 1'b0;
    logic       steady_tx    = 1'b0;
    logic       steady_rx    = 1'b0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    datagram_header_deframer u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_byte_value     (s_byte_value),
        .s_end_of_buffer  (s_end_of_buffer),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_flag_bits      (m_flag_bits),
        .m_message_id     (m_message_id),
        .m_name_length    (m_name_length),
        .m_payload_length (m_payload_length),
        .m_environment    (m_environment),
        .m_section_byte   (m_section_byte),
        .m_frame_length   (m_frame_length),
        .m_last           (m_last)
    );

    dhd_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_byte_value     (s_byte_value),
        .s_end_of_buffer  (s_end_of_buffer),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_flag_bits      (m_flag_bits),
        .m_message_id     (m_message_id),
        .m_name_length    (m_name_length),
        .m_payload_length (m_payload_length),
        .m_environment    (m_environment),
        .m_section_byte   (m_section_byte),
        .m_frame_length   (m_frame_length),
        .m_last           (m_last),
        .fail_count       (fail_count),
        .outstanding      (outstanding),
        .results_checked  (results_checked),
        .frames_done      (frames_done),
        .buffers_short    (buffers_short)
    );

    // Section byte with a fair share of zeros to exercise the zero fill
    function automatic logic [7:0] section_fill();
        return ($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom);
    endfunction

    task automatic add_header(input logic [15:0] flags, input logic [15:0] id,
                              input logic [7:0] nlen, input logic [15:0] dlen,
                              input logic [15:0] env);
        buf_q.push_back(flags[15:8]);
        buf_q.push_back(flags[7:0]);
        buf_q.push_back(id[15:8]);
        buf_q.push_back(id[7:0]);
        buf_q.push_back(8'($urandom));
        buf_q.push_back(nlen);
        buf_q.push_back(dlen[15:8]);
        buf_q.push_back(dlen[7:0]);
        buf_q.push_back(env[15:8]);
        buf_q.push_back(env[7:0]);
        buf_q.push_back(8'($urandom));
        buf_q.push_back(8'($urandom));
    endtask

    // One input beat, after a random gap; runs of zero gap come in stretches
    task automatic send_byte(input logic [7:0] b, input logic eob);
        int gap;
        if (bytes_sent % 64 == 0) steady_tx = ($urandom_range(0, 3) == 0);
        gap = steady_tx ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_byte_value    <= b;
        s_end_of_buffer <= eob;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    // Send the built buffer, end flag on its last byte; ignored tail not counted
    task automatic send_buffer(input int ignored_tail);
        foreach (buf_q[i]) send_byte(buf_q[i], i == buf_q.size() - 1);
        items_sent += buf_q.size() - ignored_tail;
        buffers_sent++;
        buf_q.delete();
    endtask

    task automatic random_buffer();
        int         shape;
        int         len;
        int         tail;
        logic [7:0] nlen;
        logic [15:0] dlen;
        shape = $urandom_range(0, 9);
        tail  = 0;
        if (shape == 9) begin
            // noise: random bytes, header fields arbitrary, almost always too short
            len = $urandom_range(1, 24);
            repeat (len) buf_q.push_back(8'($urandom));
        end else begin
            nlen = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(7, 40))
                                                : 8'($urandom_range(0, 6));
            dlen = ($urandom_range(0, 15) == 0) ? 16'($urandom_range(9, 60))
                                                : 16'($urandom_range(0, 8));
            add_header(16'($urandom), 16'($urandom), nlen, dlen, 16'($urandom));
            repeat (int'(nlen) + int'(dlen)) buf_q.push_back(section_fill());
            if (shape == 8) begin
                // cut the frame short anywhere, header included
                len = $urandom_range(1, buf_q.size() - 1);
                while (buf_q.size() > len) void'(buf_q.pop_back());
            end else if (shape >= 6) begin
                tail = $urandom_range(1, 4);
                repeat (tail) buf_q.push_back(8'($urandom));
            end
        end
        send_buffer(tail);
    endtask

    // Receiver: random gaps per beat, one long hold-off while the sender keeps going
    initial begin
        int beats;
        int gap;
        beats = 0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (beats % 64 == 0) steady_rx = ($urandom_range(0, 3) == 0);
            if (beats == HOLD_AT) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            gap = steady_rx ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            beats++;
        end
    end

    // Watchdog on cycles without any beat moving
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("tb_top: no beat moved for %0d cycles", STALL_LIMIT);
                $display("tb_top: done, errors");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Stimulus and verdict
    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // all-ones flag, id and environment fields, empty sections, buffer ends on the header's last byte
        add_header(16'hFFFF, 16'hFFFF, 8'h00, 16'h0000, 16'hFFFF);
        send_buffer(0);
        // single zero byte buffer: too short with no byte result
        buf_q.push_back(8'h00);
        send_buffer(0);
        // one-byte sections, zero name byte, one ignored trailing byte with the end flag
        add_header(16'h8001, 16'h0100, 8'h01, 16'h0001, 16'h7FFE);
        buf_q.push_back(8'h00);
        buf_q.push_back(8'hAB);
        buf_q.push_back(8'h55);
        send_buffer(1);

        while (items_sent < ITEM_TARGET) begin
            if (!big_done && items_sent > ITEM_TARGET / 2) begin
                // longest name, payload length using its upper byte
                add_header(16'($urandom), 16'($urandom), 8'hFF, 16'h0100, 16'($urandom));
                repeat (255 + 256) buf_q.push_back(section_fill());
                send_buffer(0);
                big_done = 1'b1;
            end else begin
                random_buffer();
            end
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);

        $display("tb_top: %0d bytes in %0d buffers, %0d result beats checked",
                 bytes_sent, buffers_sent, results_checked);
        $display("tb_top: %0d frames completed, %0d buffers ended short",
                 frames_done, buffers_short);
        if (fail_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/dhd_pkg.sv
hw/rtl/dhd_core.sv
hw/rtl/dhd_fifo.sv
hw/rtl/datagram_header_deframer.sv
tb/dhd_checker.sv
tb/tb_top.sv
